>>> hw/rtl/rtt_pkg.sv
// Shared types and constants for the repeating timer table.
package rtt_pkg;

  localparam int unsigned NumSlotsDefault = 8;

  localparam int unsigned TagW    = 8;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned IdW     = 32;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned FiredW  = 4;

  typedef enum logic [1:0] {
    CMD_ADD     = 2'd0,
    CMD_DEL_TAG = 2'd1,
    CMD_DEL_ID  = 2'd2,
    CMD_TICK    = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    KIND_ADDED     = 3'd0,
    KIND_DELETED   = 3'd1,
    KIND_NOT_FOUND = 3'd2,
    KIND_FULL      = 3'd3,
    KIND_FIRED     = 3'd4,
    KIND_TICK_DONE = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD,
    ST_WALK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [TagW-1:0]    tag;
    logic [PeriodW-1:0] period;
    logic [CountW-1:0]  remaining;
    logic [TimeW-1:0]   run_stamp;
    logic [IdW-1:0]     id;
  } slot_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;
    logic add_exec;
    logic walk_step;
    logic emit_final;
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
    logic head_fire;
    logic walk_last;
  } dp_status_t;

endpackage

>>> hw/rtl/rtt_ctrl.sv
// Sequencing state machine of the repeating timer table.
module rtt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rtt_pkg::cmd_e       command_i,
  input  rtt_pkg::dp_status_t status_i,
  output rtt_pkg::ctrl_cmd_t  cmd_o
);

  rtt_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rtt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rtt_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (command_i == rtt_pkg::CMD_ADD) ? rtt_pkg::ST_ADD : rtt_pkg::ST_WALK;
        end
      end
      rtt_pkg::ST_ADD: begin
        if (status_i.out_free) begin
          state_d = rtt_pkg::ST_IDLE;
        end
      end
      rtt_pkg::ST_WALK: begin
        if ((status_i.out_free || !status_i.head_fire) && status_i.walk_last) begin
          state_d = rtt_pkg::ST_DONE;
        end
      end
      rtt_pkg::ST_DONE: begin
        if (status_i.out_free) begin
          state_d = rtt_pkg::ST_IDLE;
        end
      end
      default: state_d = rtt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      rtt_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      rtt_pkg::ST_ADD:  cmd_o.add_exec   = status_i.out_free;
      // hold the walk only when the head fires and the output is blocked
      rtt_pkg::ST_WALK: cmd_o.walk_step  = status_i.out_free || !status_i.head_fire;
      rtt_pkg::ST_DONE: cmd_o.emit_final = status_i.out_free;
      default: in_stall_o = 1'b1;
    endcase
  end

endmodule

>>> hw/rtl/rtt_datapath.sv
// Slot ring, request registers and result register of the timer table.
module rtt_datapath #(
  parameter int unsigned NUM_SLOTS = rtt_pkg::NumSlotsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rtt_pkg::ctrl_cmd_t          cmd_i,
  output rtt_pkg::dp_status_t         status_o,
  input  rtt_pkg::cmd_e               command_i,
  input  logic [rtt_pkg::TagW-1:0]    action_tag_i,
  input  logic [rtt_pkg::PeriodW-1:0] period_i,
  input  logic [rtt_pkg::CountW-1:0]  repeat_count_i,
  input  logic [rtt_pkg::IdW-1:0]     timer_id_i,
  input  logic [rtt_pkg::TimeW-1:0]   now_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  kind_o,
  output logic [rtt_pkg::IdW-1:0]     out_id_o,
  output logic [rtt_pkg::TagW-1:0]    out_tag_o,
  output logic [rtt_pkg::FiredW-1:0]  fired_count_o,
  output logic                        last_o
);

  localparam int unsigned CntW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Slot storage: index 0 is the head, lower index is newer.
  rtt_pkg::slot_t          slot_q [NUM_SLOTS];
  rtt_pkg::slot_t          slot_d [NUM_SLOTS];
  logic [NUM_SLOTS-1:0]    valid_q, valid_d;
  logic [NUM_SLOTS-1:0]    pre_full;

  // Request registers.
  rtt_pkg::cmd_e               cmd_q;
  logic [rtt_pkg::TagW-1:0]    tag_q;
  logic [rtt_pkg::PeriodW-1:0] period_q;
  logic [rtt_pkg::CountW-1:0]  rep_q;
  logic [rtt_pkg::IdW-1:0]     tid_q;
  logic [rtt_pkg::TimeW-1:0]   now_q;

  logic [rtt_pkg::IdW-1:0]    next_id_q;
  logic [CntW-1:0]            cnt_q;
  logic [rtt_pkg::FiredW-1:0] fired_q;
  logic                       found_q;

  // Result register.
  logic                       out_valid_q;
  rtt_pkg::kind_e             out_kind_q, out_kind_d;
  logic [rtt_pkg::IdW-1:0]    out_id_q, out_id_d;
  logic [rtt_pkg::TagW-1:0]   out_tag_q, out_tag_d;
  logic [rtt_pkg::FiredW-1:0] out_cnt_q, out_cnt_d;
  logic                       out_last_q, out_last_d;
  logic                       out_load, out_free;

  logic                       full, is_tick, head_fire, head_hit, head_keep;
  logic [rtt_pkg::TimeW-1:0]  elapsed;
  rtt_pkg::slot_t             head_mod, new_slot;

  assign full    = &valid_q;
  assign is_tick = (cmd_q == rtt_pkg::CMD_TICK);
  assign elapsed = now_q - slot_q[0].run_stamp;

  assign head_fire = is_tick && valid_q[0] &&
                     (elapsed >= {{(rtt_pkg::TimeW-rtt_pkg::PeriodW){1'b0}}, slot_q[0].period});
  assign head_hit  = !is_tick && valid_q[0] && !found_q &&
                     ((cmd_q == rtt_pkg::CMD_DEL_TAG) ? (slot_q[0].tag == tag_q)
                                                      : (slot_q[0].id == tid_q));

  // Update the head as it leaves for the tail of the ring.
  always_comb begin
    head_mod  = slot_q[0];
    head_keep = valid_q[0] && !head_hit;
    if (head_fire) begin
      if (slot_q[0].remaining == rtt_pkg::CountW'(1)) begin
        head_keep = 1'b0;
      end else begin
        head_mod.run_stamp = now_q;
        if (slot_q[0].remaining != '0) begin
          head_mod.remaining = slot_q[0].remaining - rtt_pkg::CountW'(1);
        end
      end
    end
  end

  always_comb begin
    new_slot.tag       = tag_q;
    new_slot.period    = period_q;
    new_slot.remaining = rep_q;
    new_slot.run_stamp = now_q;
    new_slot.id        = next_id_q;
  end

  // A slot shifts on add only while every newer slot is occupied.
  always_comb begin
    pre_full[0] = 1'b1;
    for (int i = 1; i < NUM_SLOTS; i++) begin
      pre_full[i] = pre_full[i-1] & valid_q[i-1];
    end
  end

  always_comb begin
    slot_d  = slot_q;
    valid_d = valid_q;
    if (cmd_i.add_exec && !full) begin
      slot_d[0]  = new_slot;
      valid_d[0] = 1'b1;
      for (int i = 1; i < NUM_SLOTS; i++) begin
        if (pre_full[i]) begin
          slot_d[i]  = slot_q[i-1];
          valid_d[i] = valid_q[i-1];
        end
      end
    end else if (cmd_i.walk_step) begin
      for (int i = 0; i < NUM_SLOTS - 1; i++) begin
        slot_d[i]  = slot_q[i+1];
        valid_d[i] = valid_q[i+1];
      end
      slot_d[NUM_SLOTS-1]  = head_mod;
      valid_d[NUM_SLOTS-1] = head_keep;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q    <= command_i;
      tag_q    <= action_tag_i;
      period_q <= period_i;
      rep_q    <= repeat_count_i;
      tid_q    <= timer_id_i;
      now_q    <= now_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_id_q <= '0;
      cnt_q     <= '0;
      fired_q   <= '0;
      found_q   <= 1'b0;
    end else begin
      if (cmd_i.add_exec && !full) begin
        next_id_q <= next_id_q + rtt_pkg::IdW'(1);
      end
      if (cmd_i.capture) begin
        cnt_q   <= '0;
        fired_q <= '0;
        found_q <= 1'b0;
      end else if (cmd_i.walk_step) begin
        cnt_q <= cnt_q + CntW'(1);
        if (head_fire) begin
          fired_q <= fired_q + rtt_pkg::FiredW'(1);
        end
        if (head_hit) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  // Result register: loads when empty or when its request is taken.
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_load = cmd_i.add_exec || (cmd_i.walk_step && head_fire) || cmd_i.emit_final;

  always_comb begin
    out_kind_d = rtt_pkg::KIND_FIRED;
    out_id_d   = '0;
    out_tag_d  = '0;
    out_cnt_d  = '0;
    out_last_d = 1'b1;
    priority if (cmd_i.add_exec) begin
      out_kind_d = full ? rtt_pkg::KIND_FULL : rtt_pkg::KIND_ADDED;
      out_id_d   = full ? '0 : next_id_q;
    end else if (cmd_i.emit_final) begin
      if (is_tick) begin
        out_kind_d = rtt_pkg::KIND_TICK_DONE;
        out_cnt_d  = fired_q;
      end else begin
        out_kind_d = found_q ? rtt_pkg::KIND_DELETED : rtt_pkg::KIND_NOT_FOUND;
      end
    end else begin
      out_id_d   = slot_q[0].id;
      out_tag_d  = slot_q[0].tag;
      out_last_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_kind_q <= out_kind_d;
      out_id_q   <= out_id_d;
      out_tag_q  <= out_tag_d;
      out_cnt_q  <= out_cnt_d;
      out_last_q <= out_last_d;
    end
  end

  assign status_o.out_free  = out_free;
  assign status_o.head_fire = head_fire;
  assign status_o.walk_last = (cnt_q == CntW'(NUM_SLOTS - 1));

  assign out_valid_o   = out_valid_q;
  assign kind_o        = out_kind_q;
  assign out_id_o      = out_id_q;
  assign out_tag_o     = out_tag_q;
  assign fired_count_o = out_cnt_q;
  assign last_o        = out_last_q;

endmodule

>>> hw/rtl/repeating_timer_table.sv
// Top level of the repeating timer table: controller plus slot datapath.
// Add: the new slot is written, or the table reports full, once the result register is free.
// Delete and tick: the final result is registered after the walk, once the result register
// is free; the slot ring turns one slot per cycle past the head compare/fire logic and
// holds while a fired result is blocked.
// One request is in work at a time; in_stall_o is low only between requests.
// Reset clears the valid bits, the id counter, the state machine and the result valid.
module repeating_timer_table #(
  parameter int unsigned NUM_SLOTS = rtt_pkg::NumSlotsDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  command_i,
  input  logic [rtt_pkg::TagW-1:0]    action_tag_i,
  input  logic [rtt_pkg::PeriodW-1:0] period_i,
  input  logic [rtt_pkg::CountW-1:0]  repeat_count_i,
  input  logic [rtt_pkg::IdW-1:0]     timer_id_i,
  input  logic [rtt_pkg::TimeW-1:0]   now_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  kind_o,
  output logic [rtt_pkg::IdW-1:0]     out_id_o,
  output logic [rtt_pkg::TagW-1:0]    out_tag_o,
  output logic [rtt_pkg::FiredW-1:0]  fired_count_o,
  output logic                        last_o
);

  rtt_pkg::ctrl_cmd_t  ctrl_cmd;
  rtt_pkg::dp_status_t dp_status;
  rtt_pkg::cmd_e       command;

  assign command = rtt_pkg::cmd_e'(command_i);

  // Controller: idle -> add or walk -> final result -> idle.
  rtt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  // Datapath: slots kept newest first with holes allowed; a walk rotates
  // the whole ring once so every slot returns to its place.
  rtt_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (ctrl_cmd),
    .status_o       (dp_status),
    .command_i      (command),
    .action_tag_i   (action_tag_i),
    .period_i       (period_i),
    .repeat_count_i (repeat_count_i),
    .timer_id_i     (timer_id_i),
    .now_i          (now_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .out_id_o       (out_id_o),
    .out_tag_o      (out_tag_o),
    .fired_count_o  (fired_count_o),
    .last_o         (last_o)
  );

endmodule

>>> hw/rtl/rtt_checker.sv
// Port-level checks for the repeating timer table, bound to the top level.
module rtt_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [2:0]                  kind_o,
  input logic [rtt_pkg::IdW-1:0]     out_id_o,
  input logic                        last_o
);

  // A stalled result request stays.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(out_id_o))
    else $error("result request dropped or changed while stalled");

  // Only fired results are non-final.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((kind_o == rtt_pkg::KIND_FIRED) == !last_o))
    else $error("last flag does not match result kind");

  // A taken request is worked on before the next one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken back to back");

  // While a tick still has results to give, no new request is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("request taken in the middle of a tick");

endmodule

bind repeating_timer_table rtt_checker u_rtt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .kind_o      (kind_o),
  .out_id_o    (out_id_o),
  .last_o      (last_o)
);

>>> tb/timer_table_checker.sv
// Checker for the repeating timer table: predicts each result and compares it.
module timer_table_checker
  import rtt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS = NumSlotsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               req_valid_i,
  input  logic               req_stall_i,
  input  logic [1:0]         req_cmd_i,
  input  logic [TagW-1:0]    req_tag_i,
  input  logic [PeriodW-1:0] req_period_i,
  input  logic [CountW-1:0]  req_repeat_i,
  input  logic [IdW-1:0]     req_timer_id_i,
  input  logic [TimeW-1:0]   req_now_i,
  input  logic               res_valid_i,
  input  logic               res_stall_i,
  input  logic [2:0]         res_kind_i,
  input  logic [IdW-1:0]     res_id_i,
  input  logic [TagW-1:0]    res_tag_i,
  input  logic [FiredW-1:0]  res_fired_i,
  input  logic               res_last_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    logic [TagW-1:0]    tag;
    logic [PeriodW-1:0] period;
    logic [CountW-1:0]  remaining;
    logic [TimeW-1:0]   run_stamp;
    logic [IdW-1:0]     id;
  } timer_entry_t;

  typedef struct {
    kind_e             kind;
    logic [IdW-1:0]    id;
    logic [TagW-1:0]   tag;
    logic [FiredW-1:0] fired;
    logic              last;
  } timer_result_t;

  timer_entry_t  timers[$];            // newest first
  timer_result_t expected_results[$];
  logic [IdW-1:0] next_id;
  int mismatches;

  assign fail_count_o = mismatches;

  task automatic push_result(input kind_e kind, input logic [IdW-1:0] id,
                             input logic [TagW-1:0] tag, input logic [FiredW-1:0] fired,
                             input logic last);
    timer_result_t r;
    r.kind  = kind;
    r.id    = id;
    r.tag   = tag;
    r.fired = fired;
    r.last  = last;
    expected_results.push_back(r);
  endtask

  task automatic predict_request(input cmd_e cmd, input logic [TagW-1:0] tag,
                                 input logic [PeriodW-1:0] period,
                                 input logic [CountW-1:0] rep,
                                 input logic [IdW-1:0] tid, input logic [TimeW-1:0] now);
    timer_entry_t e;
    timer_entry_t kept[$];
    int hit;
    int fired;
    logic [TimeW-1:0] elapsed;
    hit = -1;
    fired = 0;
    case (cmd)
      CMD_ADD: begin
        if (timers.size() >= NUM_SLOTS) begin
          push_result(KIND_FULL, '0, '0, '0, 1'b1);
        end else begin
          e.tag       = tag;
          e.period    = period;
          e.remaining = rep;
          e.run_stamp = now;
          e.id        = next_id;
          timers.push_front(e);
          push_result(KIND_ADDED, next_id, '0, '0, 1'b1);
          next_id = next_id + 1'b1;
        end
      end
      CMD_DEL_TAG, CMD_DEL_ID: begin
        // Drop only the newest match.
        for (int i = 0; i < timers.size() && hit < 0; i++) begin
          if (cmd == CMD_DEL_TAG ? timers[i].tag == tag : timers[i].id == tid) hit = i;
        end
        if (hit >= 0) begin
          timers.delete(hit);
          push_result(KIND_DELETED, '0, '0, '0, 1'b1);
        end else begin
          push_result(KIND_NOT_FOUND, '0, '0, '0, 1'b1);
        end
      end
      default: begin
        foreach (timers[i]) begin
          e = timers[i];
          elapsed = now - e.run_stamp;
          if (elapsed >= TimeW'(e.period)) begin
            push_result(KIND_FIRED, e.id, e.tag, '0, 1'b0);
            fired++;
            if (e.remaining != 1) begin
              e.run_stamp = now;
              if (e.remaining > 1) e.remaining = e.remaining - 1'b1;
              kept.push_back(e);
            end
          end else begin
            kept.push_back(e);
          end
        end
        timers = kept;
        push_result(KIND_TICK_DONE, '0, '0, FiredW'(fired), 1'b1);
      end
    endcase
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result();
    timer_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: kind %0d id %0h tag %0h fired %0d last %0b",
               $time, res_kind_i, res_id_i, res_tag_i, res_fired_i, res_last_i);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      check_field("kind", 32'(want.kind), 32'(res_kind_i));
      check_field("out_id", want.id, res_id_i);
      check_field("out_tag", 32'(want.tag), 32'(res_tag_i));
      check_field("fired_count", 32'(want.fired), 32'(res_fired_i));
      check_field("last", 32'(want.last), 32'(res_last_i));
    end
  endtask

  // Compare before predicting: a result never belongs to a request taken at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timers.delete();
      expected_results.delete();
      next_id = '0;
      mismatches = 0;
      pending_o <= 0;
    end else begin
      if (res_valid_i && !res_stall_i) check_result();
      if (req_valid_i && !req_stall_i) begin
        predict_request(cmd_e'(req_cmd_i), req_tag_i, req_period_i, req_repeat_i,
                        req_timer_id_i, req_now_i);
      end
      pending_o <= expected_results.size();
    end
  end

endmodule

>>> tb/tb_repeating_timer_table.sv
// Testbench top for the repeating timer table: request stimulus, result stalls, verdict.
module tb_repeating_timer_table;
  import rtt_pkg::*;

  localparam int unsigned NumSlots   = NumSlotsDefault;
  // Generous bound: 279 requests, each up to 9 results with random stalls and gaps.
  localparam int          CycleLimit = 400000;
  localparam int          IdlePct    = 36;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  // Request channel, all known from time zero.
  logic               req_valid    = 1'b0;
  logic               req_stall;
  logic [1:0]         req_cmd      = CMD_TICK;
  logic [TagW-1:0]    req_tag      = '0;
  logic [PeriodW-1:0] req_period   = '0;
  logic [CountW-1:0]  req_repeat   = '0;
  logic [IdW-1:0]     req_timer_id = '0;
  logic [TimeW-1:0]   req_now      = '0;

  // Result channel.
  logic               res_valid;
  logic               res_stall = 1'b0;
  logic [2:0]         res_kind;
  logic [IdW-1:0]     res_id;
  logic [TagW-1:0]    res_tag;
  logic [FiredW-1:0]  res_fired;
  logic               res_last;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int req_gap_pct = IdlePct;
  int res_stall_pct = IdlePct;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  repeating_timer_table #(
    .NUM_SLOTS(NumSlots)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_valid),
    .in_stall_o    (req_stall),
    .command_i     (req_cmd),
    .action_tag_i  (req_tag),
    .period_i      (req_period),
    .repeat_count_i(req_repeat),
    .timer_id_i    (req_timer_id),
    .now_i         (req_now),
    .out_valid_o   (res_valid),
    .out_stall_i   (res_stall),
    .kind_o        (res_kind),
    .out_id_o      (res_id),
    .out_tag_o     (res_tag),
    .fired_count_o (res_fired),
    .last_o        (res_last)
  );

  timer_table_checker #(
    .NUM_SLOTS(NumSlots)
  ) checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_valid),
    .req_stall_i   (req_stall),
    .req_cmd_i     (req_cmd),
    .req_tag_i     (req_tag),
    .req_period_i  (req_period),
    .req_repeat_i  (req_repeat),
    .req_timer_id_i(req_timer_id),
    .req_now_i     (req_now),
    .res_valid_i   (res_valid),
    .res_stall_i   (res_stall),
    .res_kind_i    (res_kind),
    .res_id_i      (res_id),
    .res_tag_i     (res_tag),
    .res_fired_i   (res_fired),
    .res_last_i    (res_last),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  // Stall the result side at random; the percentage drops to zero for the quiet stretch.
  always @(posedge clk_i) begin
    res_stall <= ($urandom_range(99) < res_stall_pct);
  end

  // Watchdog: end the run if the table hangs or a result never shows up.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one request. Valid stays high after acceptance so back-to-back requests never
  // lower and raise it in the same step; a gap lowers it first.
  task automatic send_request(input cmd_e cmd, input logic [TagW-1:0] tag,
                              input logic [PeriodW-1:0] period,
                              input logic [CountW-1:0] rep,
                              input logic [IdW-1:0] tid, input logic [TimeW-1:0] now);
    while ($urandom_range(99) < req_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk_i);
    end
    req_valid    <= 1'b1;
    req_cmd      <= cmd;
    req_tag      <= tag;
    req_period   <= period;
    req_repeat   <= rep;
    req_timer_id <= tid;
    req_now      <= now;
    // Hold the payload until an edge sees valid high and stall low.
    @(posedge clk_i);
    while (req_stall) @(posedge clk_i);
  endtask

  // Hold off new requests until every predicted result has come back. The first edge
  // lets the checker's count catch up with the request just taken.
  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  initial begin : stimulus
    cmd_e              cmd;
    logic [TagW-1:0]    tag;
    logic [PeriodW-1:0] period;
    logic [CountW-1:0]  rep;
    logic [IdW-1:0]     tid;
    logic [TimeW-1:0]   clock_now;
    logic [IdW-1:0]     ids_issued;
    int pick;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: empty table, extremes, time wrap, full table, all-fire tick.
    send_request(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_request(CMD_DEL_TAG, 8'h00, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_request(CMD_DEL_ID, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Zero period, one shot: fires on the very next tick and is dropped.
    send_request(CMD_ADD, 8'h00, 16'h0000, 16'h0001, 32'h0, 32'h0);
    send_request(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_request(CMD_ADD, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Last run just below the wrap point so the next tick measures across it.
    send_request(CMD_ADD, 8'h5A, 16'd10, 16'h0000, 32'h0, 32'hFFFF_FFF8);
    send_request(CMD_ADD, 8'h5A, 16'd3, 16'd2, 32'h0, 32'hFFFF_FFFC);
    for (int i = 1; i <= 5; i++) begin
      send_request(CMD_ADD, 8'(i), 16'd1000, 16'd3, 32'h0, 32'h0);
    end
    // Table is full now: the add is refused and no id is spent.
    send_request(CMD_ADD, 8'hA5, 16'h5555, 16'hAAAA, 32'h0, 32'h1234_5678);
    send_request(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0, 32'd3);
    // Far enough ahead that every timer fires; the two-shot one runs out.
    send_request(CMD_TICK, 8'h00, 16'h0000, 16'h0000, 32'h0, 32'h0001_0002);
    send_request(CMD_DEL_TAG, 8'h5A, 16'h0000, 16'h0000, 32'h0, 32'h0);
    send_request(CMD_DEL_ID, 8'h00, 16'h0000, 16'h0000, 32'd1, 32'h0);
    send_request(CMD_DEL_ID, 8'h00, 16'h0000, 16'h0000, 32'd1, 32'h0);
    drain_results();

    // Random part: mostly live traffic on a few tags with slowly advancing time.
    ids_issued = 32'd8;
    clock_now  = 32'h0002_0000;
    for (int n = 0; n < 260; n++) begin
      // Quiet stretch: no gaps and no stalls at all.
      if (n == 100) begin
        req_gap_pct   = 0;
        res_stall_pct = 0;
      end else if (n == 160) begin
        req_gap_pct   = IdlePct;
        res_stall_pct = IdlePct;
      end
      if (n == 130 || n == 210) drain_results();

      pick = $urandom_range(99);
      if (pick < 30)      cmd = CMD_ADD;
      else if (pick < 45) cmd = CMD_DEL_TAG;
      else if (pick < 60) cmd = CMD_DEL_ID;
      else                cmd = CMD_TICK;

      tag = ($urandom_range(99) < 80) ? TagW'($urandom_range(7)) : TagW'($urandom());

      pick = $urandom_range(99);
      if (pick < 70)      period = PeriodW'($urandom_range(20));
      else if (pick < 90) period = PeriodW'($urandom());
      else                period = (pick < 95) ? '0 : '1;

      pick = $urandom_range(99);
      if (pick < 40)      rep = '0;
      else if (pick < 80) rep = CountW'($urandom_range(4, 1));
      else                rep = CountW'($urandom());

      // Aim deletes by id at recently issued ids most of the time.
      tid = ($urandom_range(99) < 70) ? ids_issued - IdW'($urandom_range(10)) : $urandom();

      // Advance time slowly; now and then jump anywhere, backward included.
      if ($urandom_range(99) < 3) clock_now = $urandom();
      else                        clock_now = clock_now + TimeW'($urandom_range(6));

      if (cmd == CMD_ADD) ids_issued = ids_issued + 1'b1;
      send_request(cmd, tag, period, rep, tid, clock_now);
    end

    drain_results();
    // Give a late extra result time to show up as a failure.
    repeat (NumSlots + 4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/rtt_pkg.sv
hw/rtl/rtt_ctrl.sv
hw/rtl/rtt_datapath.sv
hw/rtl/repeating_timer_table.sv
hw/rtl/rtt_checker.sv
tb/timer_table_checker.sv
tb/tb_repeating_timer_table.sv
